>>> src/iir4_lowpass_audio_filter_core_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef IIR4_LOWPASS_AUDIO_FILTER_CORE_MACROS_SVH
`define IIR4_LOWPASS_AUDIO_FILTER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

>>> src/iir4lp_pkg.sv
package iir4lp_pkg;

  localparam int STEP_W        = 5;
  localparam int COEF_TAB_W    = 24;
  localparam int COEF_TAB_FRAC = 20;
  localparam int NUM_RATES     = 4;
  localparam int NUM_COEFS     = 5;

  localparam logic [STEP_W-1:0] STEP_FIRST = 5'd1;
  localparam logic [STEP_W-1:0] STEP_OUT   = 5'd17;

  localparam logic       REG_RATE   = 1'b0;
  localparam logic [1:0] RATE_RESET = 2'd1;

  typedef enum logic [2:0] {
    SEQ_NEXT    = 3'b001,
    SEQ_WAIT_IN = 3'b010,
    SEQ_LAST    = 3'b100
  } seq_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_NODE = 2'd1,
    OP_TAPS = 2'd2,
    OP_OUT  = 2'd3
  } dp_op_t;

  typedef enum logic [2:0] {
    SRC_Z1   = 3'd0,
    SRC_Z2   = 3'd1,
    SRC_Z3   = 3'd2,
    SRC_Z4   = 3'd3,
    SRC_TAPS = 3'd4
  } src_t;

  typedef enum logic [2:0] {
    COEF_G  = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_B3 = 3'd3,
    COEF_B4 = 3'd4
  } coef_sel_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic mul_hi;
    logic round_en;
    logic round_out;
  } mac_ctrl_t;

  typedef struct packed {
    seq_t      seq;
    dp_op_t    op;
    src_t      src;
    coef_sel_t coef;
    mac_ctrl_t mac;
  } ucode_t;

  // Rows are 44.1, 48, 88.2 and 96 kHz; columns are g, b1, b2, b3, b4 in Q3.20.
  localparam logic signed [COEF_TAB_W-1:0] COEF_Q20 [NUM_RATES][NUM_COEFS] = '{
    '{24'sd647235, 24'sd3184033, 24'sd3732318, 24'sd1984582, 24'sd406257},
    '{24'sd448050, 24'sd2439861, 24'sd2392801, 24'sd1081585, 24'sd205970},
    '{24'sd44710, -24'sd1076383, 24'sd1124555, -24'sd509774, 24'sd128383},
    '{24'sd32926, -24'sd1384769, 24'sd1359227, -24'sd649004, 24'sd152792}
  };

  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t u;
    u = '{seq: SEQ_NEXT, op: OP_NONE, src: SRC_Z1, coef: COEF_G, mac: '0};
    unique case (step)
      5'd0: begin
        u.seq = SEQ_WAIT_IN;
        u.mac.clear = 1'b1;
      end
      5'd1: begin
        u.coef = COEF_B1; u.src = SRC_Z1; u.mac.mul_en = 1'b1;
      end
      5'd2: begin
        u.coef = COEF_B1; u.src = SRC_Z1; u.mac.mul_en = 1'b1; u.mac.mul_hi = 1'b1;
      end
      5'd3: begin
        u.coef = COEF_B2; u.src = SRC_Z2; u.mac.mul_en = 1'b1;
      end
      5'd4: begin
        u.coef = COEF_B2; u.src = SRC_Z2; u.mac.mul_en = 1'b1; u.mac.mul_hi = 1'b1;
      end
      5'd5: begin
        u.coef = COEF_B3; u.src = SRC_Z3; u.mac.mul_en = 1'b1;
      end
      5'd6: begin
        u.coef = COEF_B3; u.src = SRC_Z3; u.mac.mul_en = 1'b1; u.mac.mul_hi = 1'b1;
      end
      5'd7: begin
        u.coef = COEF_B4; u.src = SRC_Z4; u.mac.mul_en = 1'b1;
      end
      5'd8: begin
        u.coef = COEF_B4; u.src = SRC_Z4; u.mac.mul_en = 1'b1; u.mac.mul_hi = 1'b1;
      end
      5'd9: begin
        u.op = OP_NONE;
      end
      5'd10: begin
        u.mac.round_en = 1'b1;
      end
      5'd11: begin
        u.op = OP_NODE;
      end
      5'd12: begin
        u.op = OP_TAPS;
        u.mac.clear = 1'b1;
      end
      5'd13: begin
        u.coef = COEF_G; u.src = SRC_TAPS; u.mac.mul_en = 1'b1;
      end
      5'd14: begin
        u.coef = COEF_G; u.src = SRC_TAPS; u.mac.mul_en = 1'b1; u.mac.mul_hi = 1'b1;
      end
      5'd15: begin
        u.op = OP_NONE;
      end
      5'd16: begin
        u.mac.round_en = 1'b1;
        u.mac.round_out = 1'b1;
      end
      5'd17: begin
        u.seq = SEQ_LAST;
        u.op = OP_OUT;
      end
      default: begin
        u.seq = SEQ_LAST;
      end
    endcase
    return u;
  endfunction

endpackage

>>> src/iir4lp_mac.sv
module iir4lp_mac
  import iir4lp_pkg::*;
#(
  parameter int COEF_W  = 23,
  parameter int TAP_W   = 38,
  parameter int ACC_W   = 61,
  parameter int RND_FB  = 20,
  parameter int RND_OUT = 28
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [TAP_W-1:0]  opnd,
  output logic signed [ACC_W-1:0]  acc
);

  localparam int SPLIT  = TAP_W / 2;
  localparam int B_W    = SPLIT + 1;
  localparam int PROD_W = COEF_W + B_W;

  logic signed [B_W-1:0]    b_op;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic                     prod_hi;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  rnd_fb;
  logic signed [ACC_W-1:0]  rnd_out;

  always_comb begin
    if (ctrl.mul_hi) begin
      b_op = B_W'($signed(opnd[TAP_W-1:SPLIT]));
    end else begin
      b_op = $signed({1'b0, opnd[SPLIT-1:0]});
    end
  end

  assign prod_ext = ACC_W'(prod);
  assign addend   = prod_hi ? (prod_ext <<< SPLIT) : prod_ext;
  assign rnd_fb   = (acc + (ACC_W'(1) <<< (RND_FB - 1))) >>> RND_FB;
  assign rnd_out  = (acc + (ACC_W'(1) <<< (RND_OUT - 1))) >>> RND_OUT;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod    <= coef * b_op;
      prod_hi <= ctrl.mul_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      acc        <= '0;
    end else begin
      prod_valid <= ctrl.mul_en;
      priority if (ctrl.clear) begin
        acc <= '0;
      end else if (ctrl.round_en) begin
        acc <= ctrl.round_out ? rnd_out : rnd_fb;
      end else if (prod_valid) begin
        acc <= acc + addend;
      end
    end
  end

endmodule

>>> src/iir4_lowpass_audio_filter_core.sv
// Fourth-order low-pass filter (direct form II, numerator 1,4,6,4,1) for signed audio
// samples, with four built-in coefficient sets chosen by the rate register at byte
// address 0 (0 = 44.1 kHz, 1 = 48 kHz after reset, 2 = 88.2 kHz, 3 = 96 kHz). Writing
// that register also clears the four delay elements. Each input beat yields exactly one
// output beat, saturated to the sample range. The filter works on one sample at a time:
// a sample is taken in program step 0 and its result is loaded into the output register
// in step 17. The single shared multiplier makes ten passes per sample (each of the five
// products is formed from two halves of its operand) under an 18-step control program.
// A result that has not been taken holds the program in its last step; the next sample
// is accepted as soon as the previous result has been loaded.
`include "iir4_lowpass_audio_filter_core_macros.svh"

module iir4_lowpass_audio_filter_core
  import iir4lp_pkg::*;
#(
  parameter int SAMPLE_BITS     = 24,
  parameter int COEF_FRAC_BITS  = 20,
  parameter int STATE_FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // sample_in
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // sample_out
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int TD_W     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int DELAY_W  = SAMPLE_BITS + 2 + STATE_FRAC_BITS;
  localparam int TAP_W    = DELAY_W + 4;
  localparam int COEF_W   = COEF_FRAC_BITS + 3;
  localparam int ACC_NEED = DELAY_W + COEF_W + 4;
  localparam int ACC_W    = (ACC_NEED > 64) ? 64 : ACC_NEED;
  localparam int COEF_UP  = (COEF_FRAC_BITS >= COEF_TAB_FRAC) ?
                            COEF_FRAC_BITS - COEF_TAB_FRAC : 0;
  localparam int COEF_DN  = (COEF_FRAC_BITS < COEF_TAB_FRAC) ?
                            COEF_TAB_FRAC - COEF_FRAC_BITS : 0;

  logic [STEP_W-1:0]             step;
  logic [STEP_W-1:0]             step_next;
  ucode_t                        uc;
  logic [1:0]                    rate;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [DELAY_W-1:0]     z1;
  logic signed [DELAY_W-1:0]     z2;
  logic signed [DELAY_W-1:0]     z3;
  logic signed [DELAY_W-1:0]     z4;
  logic signed [DELAY_W-1:0]     w;
  logic signed [TAP_W-1:0]       taps;
  logic signed [TAP_W-1:0]       taps_next;
  logic signed [SAMPLE_BITS-1:0] y;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [COEF_TAB_W-1:0]  c_tab;
  logic signed [COEF_W-1:0]      coef;
  logic signed [TAP_W-1:0]       opnd;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       x_scaled;
  logic signed [ACC_W-1:0]       node_diff;
  logic signed [DELAY_W-1:0]     w_sat;
  logic [ACC_W-DELAY_W:0]        node_top;
  logic [ACC_W-SAMPLE_BITS:0]    y_top;
  logic                          in_beat;
  logic                          out_free;
  logic                          out_load;
  logic                          cfg_wr;

  assign uc       = ucode(step);
  assign s_tready = (uc.seq == SEQ_WAIT_IN);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (uc.op == OP_OUT) && out_free;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_RATE);
  assign prdata   = (paddr[2] == REG_RATE) ? 32'(rate) : '0;
  assign m_tdata  = TD_W'($unsigned(y));

  always_comb begin
    unique case (uc.seq)
      SEQ_NEXT:    step_next = step + 1'b1;
      SEQ_WAIT_IN: step_next = s_tvalid ? step + 1'b1 : step;
      SEQ_LAST:    step_next = out_free ? '0 : step;
      default:     step_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  assign c_tab = COEF_Q20[rate][uc.coef];

  generate
    if (COEF_DN == 0) begin : g_coef_up
      assign coef = COEF_W'(c_tab) <<< COEF_UP;
    end else begin : g_coef_dn
      logic signed [COEF_TAB_W-1:0] c_rnd;
      assign c_rnd = c_tab + (COEF_TAB_W'(1) <<< (COEF_DN - 1));
      assign coef  = COEF_W'(c_rnd >>> COEF_DN);
    end
  endgenerate

  always_comb begin
    unique case (uc.src)
      SRC_Z1:   opnd = TAP_W'(z1);
      SRC_Z2:   opnd = TAP_W'(z2);
      SRC_Z3:   opnd = TAP_W'(z3);
      SRC_Z4:   opnd = TAP_W'(z4);
      SRC_TAPS: opnd = taps;
      default:  opnd = '0;
    endcase
  end

  iir4lp_mac #(
    .COEF_W  (COEF_W),
    .TAP_W   (TAP_W),
    .ACC_W   (ACC_W),
    .RND_FB  (COEF_FRAC_BITS),
    .RND_OUT (COEF_FRAC_BITS + STATE_FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (uc.mac),
    .coef (coef),
    .opnd (opnd),
    .acc  (acc)
  );

  assign x_scaled  = ACC_W'(x) <<< STATE_FRAC_BITS;
  assign node_diff = x_scaled - acc;
  assign node_top  = node_diff[ACC_W-1:DELAY_W-1];

  always_comb begin
    if ((&node_top) || !(|node_top)) begin
      w_sat = node_diff[DELAY_W-1:0];
    end else if (node_diff[ACC_W-1]) begin
      w_sat = {1'b1, {(DELAY_W - 1){1'b0}}};
    end else begin
      w_sat = {1'b0, {(DELAY_W - 1){1'b1}}};
    end
  end

  assign taps_next = TAP_W'(w) + TAP_W'(z4) + ((TAP_W'(z1) + TAP_W'(z3)) <<< 2)
                   + (TAP_W'(z2) <<< 2) + (TAP_W'(z2) <<< 1);

  assign y_top = acc[ACC_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&y_top) || !(|y_top)) begin
      y_sat = acc[SAMPLE_BITS-1:0];
    end else if (acc[ACC_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      x <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (uc.op == OP_NODE) begin
      w <= w_sat;
    end
    if (uc.op == OP_TAPS) begin
      taps <= taps_next;
    end
    if (out_load) begin
      y <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
      z1   <= '0;
      z2   <= '0;
      z3   <= '0;
      z4   <= '0;
    end else if (cfg_wr) begin
      rate <= pwdata[1:0];
      z1   <= '0;
      z2   <= '0;
      z3   <= '0;
      z4   <= '0;
    end else if (uc.op == OP_TAPS) begin
      z1 <= w;
      z2 <= z1;
      z3 <= z2;
      z4 <= z3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `ASSERT_IMPLIES(a_out_no_overwrite, clk, rst, out_load, !m_tvalid || m_tready)
  `ASSERT_IMPLIES(a_result_from_last_step, clk, rst, $rose(m_tvalid), $past(step) == STEP_OUT)
  `ASSERT_NEXT(a_beat_starts_program, clk, rst, in_beat, step == STEP_FIRST)

endmodule

>>> tb/iir4_lowpass_audio_filter_core_tb.sv
`timescale 1ns / 100ps

module iir4_lowpass_audio_filter_core_tb;

  localparam int SAMPLE_W    = 24;
  localparam int DELAY_W     = 34;
  localparam int STATE_FRAC  = 8;
  localparam int COEF_FRAC   = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;

  localparam logic [2:0] ADDR_RATE  = 3'd0;
  localparam logic [2:0] ADDR_SPARE = 3'd4;

  localparam logic [1:0] RATE_44K1 = 2'd0;
  localparam logic [1:0] RATE_48K  = 2'd1;
  localparam logic [1:0] RATE_88K2 = 2'd2;
  localparam logic [1:0] RATE_96K  = 2'd3;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

  logic        clk;
  logic        rst;
  logic [23:0] s_tdata;  // sample_in
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] m_tdata;  // sample_out
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count = 0;
  int cycle_count = 0;

  logic [1:0]          rate_sel;
  longint              delay_z [4];
  logic [SAMPLE_W-1:0] filtered_q [$];

  iir4_lowpass_audio_filter_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Runs one sample through the filter and advances the delay line.
  function automatic logic [SAMPLE_W-1:0] filter_sample(input logic [SAMPLE_W-1:0] raw);
    longint g, b1, b2, b3, b4;
    longint x, fb, w, taps, y;
    case (rate_sel)
      RATE_44K1: begin
        g = 647235; b1 = 3184033; b2 = 3732318; b3 = 1984582; b4 = 406257;
      end
      RATE_48K: begin
        g = 448050; b1 = 2439861; b2 = 2392801; b3 = 1081585; b4 = 205970;
      end
      RATE_88K2: begin
        g = 44710; b1 = -1076383; b2 = 1124555; b3 = -509774; b4 = 128383;
      end
      default: begin
        g = 32926; b1 = -1384769; b2 = 1359227; b3 = -649004; b4 = 152792;
      end
    endcase
    x = longint'($signed(raw)) <<< STATE_FRAC;
    fb = b1 * delay_z[0] + b2 * delay_z[1] + b3 * delay_z[2] + b4 * delay_z[3];
    w = saturate(x - ((fb + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC), DELAY_W);
    taps = w + delay_z[3] + 4 * (delay_z[0] + delay_z[2]) + 6 * delay_z[1];
    y = (g * taps + (longint'(1) <<< (COEF_FRAC + STATE_FRAC - 1)))
        >>> (COEF_FRAC + STATE_FRAC);
    y = saturate(y, SAMPLE_W);
    delay_z[3] = delay_z[2];
    delay_z[2] = delay_z[1];
    delay_z[1] = delay_z[0];
    delay_z[0] = w;
    return y[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %h, got %h", what, exp_val, act_val);
  endtask

  always @(posedge clk) begin : output_check
    logic [SAMPLE_W-1:0] exp_sample;
    if (!rst && m_tvalid && m_tready) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected output beat", 32'h0, 32'(m_tdata));
      end else begin
        exp_sample = filtered_q.pop_front();
        if (m_tdata !== exp_sample)
          report_mismatch("sample_out", 32'(exp_sample), 32'(m_tdata));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= value;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    filtered_q.push_back(filter_sample(value));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_RATE) begin
      rate_sel = data[1:0];
      for (int i = 0; i < 4; i++) delay_z[i] = 0;
    end
  endtask

  task automatic reg_read_check(input logic [2:0] addr, input logic [31:0] exp_val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== exp_val) report_mismatch("prdata", exp_val, prdata);
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample(input logic [SAMPLE_W-1:0] prev);
    int kind;
    kind = $urandom_range(99);
    if (kind < 40) return 24'($urandom);
    if (kind < 65) return 24'(int'($urandom_range(2000)) - 1000);
    if (kind < 80) begin
      case ($urandom_range(3))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return 24'h000000;
        default: return 24'hFFFFFF;
      endcase
    end
    return prev + 24'($urandom_range(16383)) - 24'h002000;
  endfunction

  task automatic test_reset_state();
    reg_read_check(ADDR_RATE, 32'(iir4lp_pkg::RATE_RESET));
  endtask

  task automatic test_extremes();
    send_sample(24'h000000);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(24'hFFFFFF);
    send_sample(24'h000001);
    send_sample(24'h000000);
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);
    wait_drained();
  endtask

  // A full-scale signal at half the sample rate drives the recursion node and
  // the output into saturation with the 44.1 kHz coefficients.
  task automatic test_saturation();
    reg_write(ADDR_RATE, {30'h3FFFFFFF, RATE_44K1});
    reg_read_check(ADDR_RATE, 32'(RATE_44K1));
    for (int i = 0; i < 8; i++) send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX);
    wait_drained();
  endtask

  // A write to an unmapped address must neither change the rate nor clear the delays.
  task automatic test_unmapped_register();
    reg_write(ADDR_SPARE, 32'h0000_0003);
    reg_read_check(ADDR_RATE, 32'(RATE_44K1));
    for (int i = 0; i < 4; i++) send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX);
    wait_drained();
  endtask

  task automatic test_random(input logic [1:0] rate, input int n_items);
    logic [SAMPLE_W-1:0] value;
    value = 24'($urandom);
    reg_write(ADDR_RATE, {30'($urandom), rate});
    reg_read_check(ADDR_RATE, 32'(rate));
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_drained();
      value = random_sample(value);
      send_sample(value);
    end
    wait_drained();
  endtask

  initial begin
    rst            <= 1'b1;
    s_tdata        <= '0;
    s_tvalid       <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    send_idle_pct  = 28;
    recv_idle_pct  = 60;
    rate_sel       = iir4lp_pkg::RATE_RESET;
    for (int i = 0; i < 4; i++) delay_z[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_extremes();
    test_saturation();
    test_unmapped_register();
    test_random(RATE_96K, 100);
    test_random(RATE_88K2, 100);

    send_idle_pct = 60;
    recv_idle_pct = 28;
    test_random(RATE_44K1, 100);
    test_random(RATE_48K, 100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(RATE_88K2, 100);
    test_random(RATE_96K, 100);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && filtered_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
